// File: hdl/ctess_pkg.sv
`timescale 1ns / 1ps
package ctess_pkg;

    localparam int MAX_SEGMENTS = 64;
    localparam int MIN_SEGMENTS = 3;
    localparam int SEG_W        = 7;   // width of the segment count input
    localparam int CNT_W        = $clog2(MAX_SEGMENTS + 1);
    localparam int CORDIC_STEPS = 16;
    localparam int STEP_W       = $clog2(CORDIC_STEPS);
    localparam int COORD_W      = 24;
    localparam int RAD_W        = 23;
    localparam int TRIG_W       = 18;  // CORDIC x/y working width
    localparam int ANG_W        = 33;  // signed angle in 2^-32 turns
    localparam int PHASE_W      = 16;
    localparam int DIVQ_W       = PHASE_W + CNT_W + 1; // dividend i*65536 width
    localparam logic signed [TRIG_W-1:0] CORDIC_START = TRIG_W'(19898);
    localparam logic signed [COORD_W-1:0] COORD_MAX = 24'sh7FFFFF;
    localparam logic signed [COORD_W-1:0] COORD_MIN = 24'sh800000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_ROT,
        ST_MULX,
        ST_MULY,
        ST_OUT
    } t_state;

    // Arctangent table in 2^-32 turns
    function automatic logic [31:0] atan_turn(input logic [STEP_W-1:0] k);
        logic [31:0] v;
        unique case (k)
            4'd0:  v = 32'h20000000;
            4'd1:  v = 32'h12E4051E;
            4'd2:  v = 32'h09FB385B;
            4'd3:  v = 32'h051111D4;
            4'd4:  v = 32'h028B0D43;
            4'd5:  v = 32'h0145D7E1;
            4'd6:  v = 32'h00A2F61E;
            4'd7:  v = 32'h00517C55;
            4'd8:  v = 32'h0028BE53;
            4'd9:  v = 32'h00145F2F;
            4'd10: v = 32'h000A2F98;
            4'd11: v = 32'h000517CC;
            4'd12: v = 32'h00028BE6;
            4'd13: v = 32'h000145F3;
            4'd14: v = 32'h0000A2FA;
            default: v = 32'h0000517D;
        endcase
        return v;
    endfunction

endpackage

// File: hdl/ctess_if.sv
`timescale 1ns / 1ps
interface ctess_req_if;
    import ctess_pkg::*;
    logic                      valid;
    logic                      ready;
    logic                      mode;
    logic signed [COORD_W-1:0] center_x;
    logic signed [COORD_W-1:0] center_y;
    logic [RAD_W-1:0]          radius;
    logic [SEG_W-1:0]          segments;
    logic [31:0]               color;
    modport source (output valid, mode, center_x, center_y, radius, segments, color,
                    input ready);
    modport sink   (input valid, mode, center_x, center_y, radius, segments, color,
                    output ready);
endinterface

interface ctess_prim_if;
    import ctess_pkg::*;
    logic                      valid;
    logic                      ready;
    logic                      kind;
    logic signed [COORD_W-1:0] ax;
    logic signed [COORD_W-1:0] ay;
    logic signed [COORD_W-1:0] bx;
    logic signed [COORD_W-1:0] by;
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
    logic [31:0]               prim_color;
    logic                      last;
    modport source (output valid, kind, ax, ay, bx, by, cx, cy, prim_color, last,
                    input ready);
    modport sink   (input valid, kind, ax, ay, bx, by, cx, cy, prim_color, last,
                    output ready);
endinterface

// File: hdl/ctess_cordic.sv
`timescale 1ns / 1ps
// Iterative rotation-mode CORDIC: one micro-rotation per cycle.
module ctess_cordic
    import ctess_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [PHASE_W-1:0]       i_phase,
    output logic                     o_done,
    output logic signed [TRIG_W-1:0] o_cos,
    output logic signed [TRIG_W-1:0] o_sin
);
    logic signed [TRIG_W-1:0] r_x, r_y, n_x, n_y;
    logic signed [ANG_W-1:0]  r_z, n_z;
    logic [STEP_W-1:0]        r_k;
    logic                     r_busy, r_flip, r_done;
    logic [31:0]              w_ang;
    logic                     w_flip;
    logic signed [TRIG_W-1:0] w_dx, w_dy, w_fx, w_fy;
    logic signed [ANG_W-1:0]  w_at;

    // quadrant fold of the start angle
    always_comb begin
        w_ang  = {i_phase, 16'h0000};
        w_flip = (w_ang[31:30] == 2'd1) || (w_ang[31:30] == 2'd2);
        if (w_flip) w_ang = w_ang - 32'h80000000;
    end

    // one micro-rotation
    always_comb begin
        w_dx = r_y >>> r_k;
        w_dy = r_x >>> r_k;
        w_at = {1'b0, atan_turn(r_k)};
        if (!r_z[ANG_W-1]) begin
            n_x = r_x - w_dx;
            n_y = r_y + w_dy;
            n_z = r_z - w_at;
        end else begin
            n_x = r_x + w_dx;
            n_y = r_y - w_dy;
            n_z = r_z + w_at;
        end
        w_fx = r_flip ? -r_x : r_x;
        w_fy = r_flip ? -r_y : r_y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_k    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_k    <= '0;
            end else if (r_busy) begin
                r_k <= r_k + 1'b1;
                if (r_k == STEP_W'(CORDIC_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x    <= CORDIC_START;
            r_y    <= '0;
            r_z    <= ANG_W'(signed'(w_ang));
            r_flip <= w_flip;
        end else if (r_busy) begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
        end
    end

    // clamp to +-32767
    always_comb begin
        o_done = r_done;
        if (w_fx > TRIG_W'(32767)) o_cos = TRIG_W'(32767);
        else if (w_fx < -TRIG_W'(32767)) o_cos = -TRIG_W'(32767);
        else o_cos = w_fx;
        if (w_fy > TRIG_W'(32767)) o_sin = TRIG_W'(32767);
        else if (w_fy < -TRIG_W'(32767)) o_sin = -TRIG_W'(32767);
        else o_sin = w_fy;
    end
endmodule

// File: hdl/circle_tessellator.sv
`timescale 1ns / 1ps
// Circle tessellator: a request is taken only when the block is idle and
// yields n = clamp(segments, 3, 64) primitives. Each primitive goes through
// a restoring phase division (24 steps), a 16-step iterative CORDIC,
// the shared multiplier for x and then for y, and then the output
// transfer, which waits while the output is stalled.
module circle_tessellator
    import ctess_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    ctess_req_if.sink   i_req,
    ctess_prim_if.source o_prim
);
    t_state r_state, n_state;
    logic                      r_mode;
    logic signed [COORD_W-1:0] r_cx, r_cy, r_px, r_py, r_qx, r_qy;
    logic [RAD_W-1:0]          r_rad;
    logic [31:0]               r_col;
    logic [CNT_W-1:0]          r_n, r_i;
    logic [DIVQ_W-1:0]         r_rem, r_quo;
    logic [$clog2(DIVQ_W+1)-1:0] r_dstep;
    logic [CNT_W-1:0]          w_n;
    logic                      w_cstart, w_cdone;
    logic signed [TRIG_W-1:0]  w_cos, w_sin;
    logic signed [TRIG_W-1:0]  w_trig;
    logic signed [COORD_W-1:0] w_ctr, w_place;
    logic signed [RAD_W+TRIG_W:0] w_prod;
    logic signed [RAD_W+TRIG_W-15:0] w_off;
    logic signed [COORD_W+1:0] w_sum;
    logic [DIVQ_W:0]           w_trial;
    logic [DIVQ_W-1:0]         w_rsh;
    logic signed [COORD_W+1:0] w_p0;

    // clamp of the requested count
    always_comb begin
        if (i_req.segments < SEG_W'(MIN_SEGMENTS)) w_n = CNT_W'(MIN_SEGMENTS);
        else if (i_req.segments > SEG_W'(MAX_SEGMENTS)) w_n = CNT_W'(MAX_SEGMENTS);
        else w_n = CNT_W'(i_req.segments);
        w_p0 = (COORD_W+2)'(i_req.center_x) + (COORD_W+2)'(signed'({1'b0, i_req.radius}));
    end

    // shared multiply and saturating add: x in ST_MULX, y in ST_MULY
    always_comb begin
        w_trig  = (r_state == ST_MULY) ? w_sin : w_cos;
        w_ctr   = (r_state == ST_MULY) ? r_cy : r_cx;
        w_prod  = signed'({1'b0, r_rad}) * w_trig + (RAD_W+TRIG_W+1)'(16384);
        w_off   = w_prod[RAD_W+TRIG_W:15];
        w_sum   = (COORD_W+2)'(w_ctr) + (COORD_W+2)'(w_off);
        if (w_sum > (COORD_W+2)'(COORD_MAX)) w_place = COORD_MAX;
        else if (w_sum < (COORD_W+2)'(COORD_MIN)) w_place = COORD_MIN;
        else w_place = w_sum[COORD_W-1:0];
    end

    // restoring division step: i*65536 / n, one quotient bit per cycle
    always_comb begin
        w_rsh   = {r_rem[DIVQ_W-2:0], r_quo[DIVQ_W-1]};
        w_trial = {1'b0, w_rsh} - (DIVQ_W+1)'(r_n);
    end

    // sequencer
    always_comb begin
        n_state  = r_state;
        w_cstart = 1'b0;
        unique case (r_state)
            ST_IDLE: if (i_req.valid) n_state = ST_DIV;
            ST_DIV: if (r_dstep == '0) begin
                n_state  = ST_ROT;
                w_cstart = 1'b1;
            end
            ST_ROT:  if (w_cdone) n_state = ST_MULX;
            ST_MULX: n_state = ST_MULY;
            ST_MULY: n_state = ST_OUT;
            ST_OUT: if (o_prim.ready) n_state = (r_i == r_n) ? ST_IDLE : ST_DIV;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else          r_state <= n_state;
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: if (i_req.valid) begin
                r_mode <= i_req.mode;
                r_cx   <= i_req.center_x;
                r_cy   <= i_req.center_y;
                r_rad  <= i_req.radius;
                r_col  <= i_req.color;
                r_n    <= w_n;
                r_i    <= CNT_W'(1);
                r_py   <= i_req.center_y;
                r_px   <= (w_p0 > (COORD_W+2)'(COORD_MAX)) ? COORD_MAX
                          : w_p0[COORD_W-1:0];
                r_rem  <= '0;
                r_quo  <= {1'b0, CNT_W'(1), 16'h0000};
                r_dstep <= ($clog2(DIVQ_W+1))'(DIVQ_W);
            end
            ST_DIV: if (r_dstep != '0) begin
                r_dstep <= r_dstep - 1'b1;
                r_quo   <= {r_quo[DIVQ_W-2:0], ~w_trial[DIVQ_W]};
                r_rem   <= w_trial[DIVQ_W] ? w_rsh : w_trial[DIVQ_W-1:0];
            end
            ST_MULX: r_qx <= w_place;
            ST_MULY: r_qy <= w_place;
            ST_OUT: if (o_prim.ready) begin
                r_px  <= r_qx;
                r_py  <= r_qy;
                r_i   <= r_i + 1'b1;
                r_rem <= '0;
                r_quo <= {1'b0, r_i + 1'b1, 16'h0000};
                r_dstep <= ($clog2(DIVQ_W+1))'(DIVQ_W);
            end
            default: ;
        endcase
    end

    ctess_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_cstart),
        .i_phase (r_quo[PHASE_W-1:0]),
        .o_done  (w_cdone),
        .o_cos   (w_cos),
        .o_sin   (w_sin)
    );

    // output transfer
    always_comb begin
        i_req.ready       = (r_state == ST_IDLE);
        o_prim.valid      = (r_state == ST_OUT);
        o_prim.kind       = r_mode;
        o_prim.ax         = r_mode ? r_cx : r_px;
        o_prim.ay         = r_mode ? r_cy : r_py;
        o_prim.bx         = r_mode ? r_px : r_qx;
        o_prim.by         = r_mode ? r_py : r_qy;
        o_prim.cx         = r_mode ? r_qx : '0;
        o_prim.cy         = r_mode ? r_qy : '0;
        o_prim.prim_color = r_col;
        o_prim.last       = (r_i == r_n);
    end
endmodule

// File: hdl/ctess_checker.sv
`timescale 1ns / 1ps
module ctess_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic out_kind,
    input logic out_last
);
    // no new request while primitives are being produced
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> !in_ready) else $error("ready while emitting");
    // a stalled primitive holds its kind and last flag
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_last))
        else $error("stalled primitive changed");
    // after the last primitive the block goes idle
    a_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && out_ready && out_last |=> in_ready)
        else $error("not idle after last");
    // accepted request drops ready
    a_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_valid && in_ready |=> !in_ready) else $error("ready after transfer");
endmodule

bind circle_tessellator ctess_checker u_ctess_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .in_valid  (i_req.valid),
    .in_ready  (i_req.ready),
    .out_valid (o_prim.valid),
    .out_ready (o_prim.ready),
    .out_kind  (o_prim.kind),
    .out_last  (o_prim.last)
);
